/* src/smgl_pkg.sv */
// ----------------------------------------------------------------------------
// smgl_pkg: shared types and constants for the sprite markup glyph layout
// Character codes, register map, parse modes and result records.
// ----------------------------------------------------------------------------
package smgl_pkg;

	// character codes of the markup
	localparam logic [7:0] CH_LBRACK = 8'h5B;
	localparam logic [7:0] CH_RBRACK = 8'h5D;
	localparam logic [7:0] CH_HASH   = 8'h23;
	localparam logic [7:0] CH_PCT    = 8'h25;
	localparam logic [7:0] CH_AT     = 8'h40;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_0      = 8'h30;
	localparam logic [7:0] CH_9      = 8'h39;

	// register map, index = paddr[4:2]
	localparam int PADDR_W = 5;
	localparam logic [2:0] REG_SECTION    = 3'd0;
	localparam logic [2:0] REG_ORIGIN_X   = 3'd1;
	localparam logic [2:0] REG_ORIGIN_Y   = 3'd2;
	localparam logic [2:0] REG_INIT_SIZE  = 3'd3;
	localparam logic [2:0] REG_INIT_COLOR = 3'd4;

	// register reset values
	localparam logic [3:0]  RST_SECTION    = 4'd1;
	localparam logic [15:0] RST_ORIGIN_X   = 16'd0;
	localparam logic [15:0] RST_ORIGIN_Y   = 16'd0;
	localparam logic [9:0]  RST_INIT_SIZE  = 10'd30;
	localparam logic [23:0] RST_INIT_COLOR = 24'hFFFFFF;

	localparam logic [9:0] SIZE_MAX = 10'd1023;

	// glyphs per character and result queue
	localparam int MAX_RES  = 3;
	localparam int RQ_DEPTH = 4;
	localparam int RQ_PTR_W = 2;

	typedef enum logic [8:0] {
		M_TOP    = 9'b000000001,
		M_TERM   = 9'b000000010,
		M_BODY   = 9'b000000100,
		M_SIZE   = 9'b000001000,
		M_COLCHK = 9'b000010000,
		M_CSP    = 9'b000100000,
		M_CDIG   = 9'b001000000,
		M_DRAW   = 9'b010000000,
		M_DONE   = 9'b100000000
	} mode_t;

	typedef struct packed {
		logic [3:0]  section;
		logic [15:0] origin_x;
		logic [15:0] origin_y;
		logic [9:0]  init_size;
		logic [23:0] init_color;
	} cfg_t;

	typedef struct packed {
		mode_t       mode;
		logic [1:0]  opener_count;
		logic [9:0]  size;
		logic [23:0] color;
		logic [9:0]  accum;
		logic [1:0]  field;
	} pstate_t;

	// lookahead window: up to three bytes
	typedef struct packed {
		logic [7:0] b0;
		logic [7:0] b1;
		logic [7:0] b2;
		logic [1:0] count;
	} queue_t;

	typedef struct packed {
		logic [7:0]  glyph;
		logic [15:0] pos_x;
		logic [15:0] pos_y;
		logic [9:0]  size;
		logic [23:0] color;
	} glyph_t;

	typedef struct packed {
		logic [MAX_RES-1:0]         emit;
		glyph_t [MAX_RES-1:0]       rec;
	} push_t;

	typedef struct packed {
		glyph_t g;
		logic   last;
	} rq_entry_t;

endpackage

/* src/smgl_in_if.sv */
// ----------------------------------------------------------------------------
// smgl_in_if: character request channel
// Valid/ready channel carrying one text byte and its end-of-text mark.
// ----------------------------------------------------------------------------
interface smgl_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] char_code;
	logic       last_char;

	modport source (output valid, char_code, last_char, input ready);
	modport sink   (input valid, char_code, last_char, output ready);
endinterface

/* src/smgl_out_if.sv */
// ----------------------------------------------------------------------------
// smgl_out_if: glyph request channel
// Valid/ready channel carrying one glyph with position, size and color.
// ----------------------------------------------------------------------------
interface smgl_out_if;
	logic        valid;
	logic        ready;
	logic [7:0]  glyph;
	logic [15:0] pos_x;
	logic [15:0] pos_y;
	logic [9:0]  glyph_size;
	logic [7:0]  red;
	logic [7:0]  green;
	logic [7:0]  blue;
	logic        end_of_run;

	modport source (output valid, glyph, pos_x, pos_y, glyph_size, red, green, blue,
		end_of_run, input ready);
	modport sink   (input valid, glyph, pos_x, pos_y, glyph_size, red, green, blue,
		end_of_run, output ready);
endinterface

/* src/sprite_markup_glyph_layout_top.sv */
// ----------------------------------------------------------------------------
// sprite_markup_glyph_layout_top: sprite markup text to glyph draw requests
// Path: an accepted request waits in the input register until the result queue has room,
// and its glyphs are then written to the queue. Throughput: one character per cycle; a character
// releases up to three glyphs, and input stalls while the 4-entry result queue holds 2 or more.
// Reset: arst_n loads register defaults, restarts the parser and empties the queue.
// ----------------------------------------------------------------------------
module sprite_markup_glyph_layout_top #(
	parameter int COORD_BITS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// configuration
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [smgl_pkg::PADDR_W-1:0]  paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready,
	// text in, glyphs out
	smgl_in_if.sink                       char_in,
	smgl_out_if.source                    glyph_out
);
	import smgl_pkg::*;

	cfg_t cfg;

	// input register
	logic       valid_s1;
	logic [7:0] char_s1;
	logic       last_s1;
	logic       in_rdy;
	logic       adv;
	logic       room;

	// parser state, carried from character to character
	pstate_t               st_q;
	logic [7:0]            held0_q, held1_q;
	logic [1:0]            hc_q;
	logic [COORD_BITS-1:0] cx_q, cy_q;

	// step chain: three steps cover the held bytes plus the new one
	pstate_t               st_c [MAX_RES+1];
	queue_t                q_c  [MAX_RES+1];
	logic [COORD_BITS-1:0] cx_c [MAX_RES+1];
	logic [COORD_BITS-1:0] cy_c [MAX_RES+1];
	logic [MAX_RES-1:0]    emit_c;
	glyph_t [MAX_RES-1:0]  rec_c;
	push_t                 push;
	pstate_t               st_rst;

	smgl_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// the registered character moves on only when the queue can take
	// every glyph it might release; no path from glyph_out.ready to here
	assign adv           = valid_s1 && room;
	assign in_rdy        = !valid_s1 || adv;
	assign char_in.ready = in_rdy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_rdy) begin
			valid_s1 <= char_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (char_in.valid && in_rdy) begin
			char_s1 <= char_in.char_code;
			last_s1 <= char_in.last_char;
		end
	end

	// lookahead window: held bytes first, then the new character
	always_comb begin
		st_c[0] = st_q;
		cx_c[0] = cx_q;
		cy_c[0] = cy_q;
		q_c[0].count = hc_q + 2'd1;
		case (hc_q)
			2'd0: begin
				q_c[0].b0 = char_s1;
				q_c[0].b1 = 8'd0;
				q_c[0].b2 = 8'd0;
			end
			2'd1: begin
				q_c[0].b0 = held0_q;
				q_c[0].b1 = char_s1;
				q_c[0].b2 = 8'd0;
			end
			default: begin
				q_c[0].b0 = held0_q;
				q_c[0].b1 = held1_q;
				q_c[0].b2 = char_s1;
			end
		endcase
	end

	for (genvar i = 0; i < MAX_RES; i++) begin : g_step
		smgl_step #(.COORD_BITS(COORD_BITS)) u_step (
			.st_i     (st_c[i]),
			.q_i      (q_c[i]),
			.fin      (last_s1),
			.section  (cfg.section),
			.origin_x (cfg.origin_x),
			.cx_i     (cx_c[i]),
			.cy_i     (cy_c[i]),
			.st_o     (st_c[i+1]),
			.q_o      (q_c[i+1]),
			.cx_o     (cx_c[i+1]),
			.cy_o     (cy_c[i+1]),
			.emit     (emit_c[i]),
			.rec      (rec_c[i])
		);
	end

	// restart values for the next text
	always_comb begin
		st_rst.mode         = M_TOP;
		st_rst.opener_count = 2'd0;
		st_rst.size         = cfg.init_size;
		st_rst.color        = cfg.init_color;
		st_rst.accum        = 10'd0;
		st_rst.field        = 2'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q.mode         <= M_TOP;
			st_q.opener_count <= 2'd0;
			st_q.size         <= RST_INIT_SIZE;
			st_q.color        <= RST_INIT_COLOR;
			st_q.accum        <= 10'd0;
			st_q.field        <= 2'd0;
			held0_q           <= 8'd0;
			held1_q           <= 8'd0;
			hc_q              <= 2'd0;
			cx_q              <= COORD_BITS'(RST_ORIGIN_X);
			cy_q              <= COORD_BITS'(RST_ORIGIN_Y);
		end else if (adv) begin
			if (last_s1) begin
				// final byte: held bytes were flushed above, start over
				st_q    <= st_rst;
				held0_q <= 8'd0;
				held1_q <= 8'd0;
				hc_q    <= 2'd0;
				cx_q    <= COORD_BITS'(cfg.origin_x);
				cy_q    <= COORD_BITS'(cfg.origin_y);
			end else begin
				st_q    <= st_c[MAX_RES];
				held0_q <= q_c[MAX_RES].b0;
				held1_q <= q_c[MAX_RES].b1;
				hc_q    <= (q_c[MAX_RES].count > 2'd2) ? 2'd2 : q_c[MAX_RES].count;
				cx_q    <= cx_c[MAX_RES];
				cy_q    <= cy_c[MAX_RES];
			end
		end
	end

	assign push.emit = emit_c & {MAX_RES{adv}};
	assign push.rec  = rec_c;

	smgl_rfifo u_rfifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.room   (room),
		.out_ch (glyph_out)
	);

endmodule

/* src/smgl_cfg.sv */
// ----------------------------------------------------------------------------
// smgl_cfg: APB register block
// Section select, cursor origin, initial size and color.
// ----------------------------------------------------------------------------
module smgl_cfg (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [smgl_pkg::PADDR_W-1:0]  paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready,
	output smgl_pkg::cfg_t                cfg
);
	import smgl_pkg::*;

	cfg_t       cfg_q;
	logic [2:0] idx;
	logic       wr_en;

	assign pready = 1'b1;
	assign idx    = paddr[PADDR_W-1:2];
	assign wr_en  = psel && penable && pwrite && pready;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.section    <= RST_SECTION;
			cfg_q.origin_x   <= RST_ORIGIN_X;
			cfg_q.origin_y   <= RST_ORIGIN_Y;
			cfg_q.init_size  <= RST_INIT_SIZE;
			cfg_q.init_color <= RST_INIT_COLOR;
		end else if (wr_en) begin
			case (idx)
				REG_SECTION:    cfg_q.section    <= pwdata[3:0];
				REG_ORIGIN_X:   cfg_q.origin_x   <= pwdata[15:0];
				REG_ORIGIN_Y:   cfg_q.origin_y   <= pwdata[15:0];
				REG_INIT_SIZE:  cfg_q.init_size  <= pwdata[9:0];
				REG_INIT_COLOR: cfg_q.init_color <= pwdata[23:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_SECTION:    prdata = {28'd0, cfg_q.section};
			REG_ORIGIN_X:   prdata = {16'd0, cfg_q.origin_x};
			REG_ORIGIN_Y:   prdata = {16'd0, cfg_q.origin_y};
			REG_INIT_SIZE:  prdata = {22'd0, cfg_q.init_size};
			REG_INIT_COLOR: prdata = {8'd0, cfg_q.init_color};
			default:        prdata = 32'd0;
		endcase
	end

endmodule

/* src/smgl_step.sv */
// ----------------------------------------------------------------------------
// smgl_step: one parse step over the lookahead window
// Runs the lookahead checks up to the first consumed byte or a stall.
// ----------------------------------------------------------------------------
module smgl_step #(
	parameter int COORD_BITS = 16
) (
	input  smgl_pkg::pstate_t        st_i,
	input  smgl_pkg::queue_t         q_i,
	input  logic                     fin,
	input  logic [3:0]               section,
	input  logic [15:0]              origin_x,
	input  logic [COORD_BITS-1:0]    cx_i,
	input  logic [COORD_BITS-1:0]    cy_i,
	output smgl_pkg::pstate_t        st_o,
	output smgl_pkg::queue_t         q_o,
	output logic [COORD_BITS-1:0]    cx_o,
	output logic [COORD_BITS-1:0]    cy_o,
	output logic                     emit,
	output smgl_pkg::glyph_t         rec
);
	import smgl_pkg::*;

	logic [7:0]  ndig;
	logic [7:0]  b0, b1, b2;
	logic        has1, has2, av1, av2;
	logic        is_dig;
	logic [3:0]  dig;
	logic [13:0] sz_acc;
	logic [7:0]  col_acc;
	logic        run;
	logic [1:0]  pop;
	mode_t       m;

	assign ndig    = CH_0 + {4'd0, section};
	assign b0      = q_i.b0;
	assign b1      = q_i.b1;
	assign b2      = q_i.b2;
	assign has1    = q_i.count > 2'd1;
	assign has2    = q_i.count == 2'd3;
	// past the final byte, missing lookahead simply fails to match
	assign av1     = has1 || fin;
	assign av2     = has2 || fin;
	assign is_dig  = b0 inside {[CH_0:CH_9]};
	assign dig     = 4'(b0 - CH_0);
	assign sz_acc  = {4'd0, st_i.accum} * 14'd10 + {10'd0, dig};
	assign col_acc = st_i.accum[7:0] * 8'd10 + {4'd0, dig};

	always_comb begin
		st_o = st_i;
		cx_o = cx_i;
		cy_o = cy_i;
		emit = 1'b0;
		rec  = '0;
		pop  = 2'd0;
		run  = q_i.count != 2'd0;
		m    = st_i.mode;

		// section opener
		if (run && m == M_TOP) begin
			if (b0 == CH_LBRACK && !av1) begin
				run = 1'b0;
			end else if (b0 == CH_LBRACK && has1 && b1 == CH_HASH && !av2) begin
				run = 1'b0;
			end else if (b0 == CH_LBRACK && has1 && b1 == CH_HASH && has2 && b2 == ndig) begin
				pop = 2'd3;
				if (st_i.opener_count != 2'd3)
					st_o.opener_count = st_i.opener_count + 2'd1;
				m   = M_TERM;
				run = 1'b0;
			end else begin
				m = M_TERM;
			end
		end

		// text closer
		if (run && m == M_TERM) begin
			if (b0 == CH_HASH && !av1) begin
				run = 1'b0;
			end else if (b0 == CH_HASH && has1 && b1 == ndig && !av2) begin
				run = 1'b0;
			end else if (b0 == CH_HASH && has1 && b1 == ndig && has2 && b2 == CH_RBRACK) begin
				m = M_DONE;
			end else begin
				m = M_BODY;
			end
		end

		// inside or outside the drawn section, tag openers
		if (run && m == M_BODY) begin
			if (st_i.opener_count != 2'd1) begin
				pop = 2'd1;
				m   = M_TOP;
				run = 1'b0;
			end else if (b0 == CH_LBRACK && !av1) begin
				run = 1'b0;
			end else if (b0 == CH_LBRACK && has1 && b1 == CH_PCT) begin
				pop            = 2'd2;
				st_o.accum     = 10'd0;
				m              = M_SIZE;
				run            = 1'b0;
			end else if (b0 == CH_LBRACK && has1 && b1 == CH_AT) begin
				pop            = 2'd2;
				st_o.accum     = 10'd0;
				st_o.field     = 2'd0;
				m              = M_CSP;
				run            = 1'b0;
			end else begin
				m = M_DRAW;
			end
		end

		// color tag allowed right after a size tag
		if (run && m == M_COLCHK) begin
			if (b0 == CH_LBRACK && !av1) begin
				run = 1'b0;
			end else if (b0 == CH_LBRACK && has1 && b1 == CH_AT) begin
				pop        = 2'd2;
				st_o.accum = 10'd0;
				st_o.field = 2'd0;
				m          = M_CSP;
				run        = 1'b0;
			end else begin
				m = M_DRAW;
			end
		end

		// skip spaces ahead of a color value
		if (run && m == M_CSP) begin
			if (b0 == CH_SPACE) begin
				pop = 2'd1;
				run = 1'b0;
			end else begin
				m = M_CDIG;
			end
		end

		// byte-consuming modes
		if (run) begin
			pop = 2'd1;
			case (m)
				M_DRAW: begin
					m = M_TOP;
					if (b0 == CH_LF) begin
						cy_o = cy_i + COORD_BITS'(st_i.size);
						cx_o = COORD_BITS'(origin_x);
					end else begin
						cx_o       = cx_i + COORD_BITS'(st_i.size >> 1);
						emit       = 1'b1;
						rec.glyph  = b0;
						rec.pos_x  = 16'(cx_o);
						rec.pos_y  = 16'(cy_i);
						rec.size   = st_i.size;
						rec.color  = st_i.color;
					end
				end
				M_SIZE: begin
					if (b0 == CH_RBRACK) begin
						st_o.size  = st_i.accum;
						st_o.accum = 10'd0;
						m          = M_COLCHK;
					end else if (is_dig) begin
						st_o.accum = (sz_acc > {4'd0, SIZE_MAX}) ? SIZE_MAX : sz_acc[9:0];
					end
				end
				M_CDIG: begin
					if (is_dig) begin
						st_o.accum = {2'd0, col_acc};
					end else begin
						case (st_i.field)
							2'd0:    st_o.color[23:16] = st_i.accum[7:0];
							2'd1:    st_o.color[15:8]  = st_i.accum[7:0];
							default: st_o.color[7:0]   = st_i.accum[7:0];
						endcase
						st_o.accum = 10'd0;
						if (st_i.field >= 2'd2) begin
							st_o.field = 2'd0;
							m          = M_DRAW;
						end else begin
							st_o.field = st_i.field + 2'd1;
							m          = M_CSP;
						end
					end
				end
				default: ; // after the closer: drop the byte
			endcase
		end

		st_o.mode = m;

		q_o.count = q_i.count - pop;
		case (pop)
			2'd1: begin
				q_o.b0 = b1;
				q_o.b1 = b2;
				q_o.b2 = 8'd0;
			end
			2'd2: begin
				q_o.b0 = b2;
				q_o.b1 = 8'd0;
				q_o.b2 = 8'd0;
			end
			2'd3: begin
				q_o.b0 = 8'd0;
				q_o.b1 = 8'd0;
				q_o.b2 = 8'd0;
			end
			default: begin
				q_o.b0 = b0;
				q_o.b1 = b1;
				q_o.b2 = b2;
			end
		endcase
	end

endmodule

/* src/smgl_rfifo.sv */
// ----------------------------------------------------------------------------
// smgl_rfifo: glyph result queue
// Takes up to three glyphs per cycle, hands out one per cycle while out_ch.ready is high.
// ----------------------------------------------------------------------------
module smgl_rfifo (
	input  logic            clk,
	input  logic            arst_n,
	input  smgl_pkg::push_t push,
	output logic            room,
	smgl_out_if.source      out_ch
);
	import smgl_pkg::*;

	rq_entry_t            mem [RQ_DEPTH];
	logic [RQ_PTR_W-1:0]  rd_q, wr_q;
	logic [RQ_PTR_W:0]    count_q;
	logic [1:0]           off1, off2, nres;
	logic                 pop;

	// pack the emitted glyphs into consecutive slots
	assign off1 = {1'b0, push.emit[0]};
	assign off2 = off1 + {1'b0, push.emit[1]};
	assign nres = off2 + {1'b0, push.emit[2]};

	// room for a full character's worth of glyphs
	assign room = count_q <= (RQ_PTR_W + 1)'(RQ_DEPTH - MAX_RES);
	assign pop  = out_ch.valid && out_ch.ready;

	always_ff @(posedge clk) begin
		if (push.emit[0])
			mem[wr_q] <= '{g: push.rec[0], last: !push.emit[1] && !push.emit[2]};
		if (push.emit[1])
			mem[wr_q + off1] <= '{g: push.rec[1], last: !push.emit[2]};
		if (push.emit[2])
			mem[wr_q + off2] <= '{g: push.rec[2], last: 1'b1};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_q    <= '0;
			wr_q    <= '0;
			count_q <= '0;
		end else begin
			wr_q    <= wr_q + nres;
			rd_q    <= rd_q + {1'b0, pop};
			count_q <= count_q + {1'b0, nres} - {2'd0, pop};
		end
	end

	assign out_ch.valid      = count_q != '0;
	assign out_ch.glyph      = mem[rd_q].g.glyph;
	assign out_ch.pos_x      = mem[rd_q].g.pos_x;
	assign out_ch.pos_y      = mem[rd_q].g.pos_y;
	assign out_ch.glyph_size = mem[rd_q].g.size;
	assign out_ch.red        = mem[rd_q].g.color[23:16];
	assign out_ch.green      = mem[rd_q].g.color[15:8];
	assign out_ch.blue       = mem[rd_q].g.color[7:0];
	assign out_ch.end_of_run = mem[rd_q].last;

endmodule

/* dv/tb.sv */
// ----------------------------------------------------------------------------
// tb: self-checking bench for the sprite markup glyph layout
// Streams sprite text into the block, predicts every glyph draw request from
// a cycle-free model of the parser, and checks each draw field by field.
// ----------------------------------------------------------------------------
module tb;
	import smgl_pkg::*;

	// one text byte waiting to be sent
	typedef struct packed {
		logic [7:0] ch;
		logic       last;
	} char_req_t;

	// one expected draw request
	typedef struct packed {
		logic [7:0]  glyph;
		logic [15:0] x;
		logic [15:0] y;
		logic [9:0]  size;
		logic [7:0]  red;
		logic [7:0]  green;
		logic [7:0]  blue;
		logic        eor;
	} draw_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	smgl_in_if  char_if ();
	smgl_out_if glyph_if ();

	sprite_markup_glyph_layout_top u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready),
		.char_in   (char_if),
		.glyph_out (glyph_if)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	char_req_t text_queue[$];     // bytes not yet offered to the block
	draw_t     draws_expected[$]; // predicted draws, oldest first
	int        mismatches = 0;
	bit        steady = 1'b0;     // no idling on either side while set

	// --------------------------------------------------------------------
	// Layout predictor: registers, parser state and the per-byte lookahead
	// --------------------------------------------------------------------
	logic [3:0]  c_section;
	logic [15:0] c_ox, c_oy;
	logic [9:0]  c_isize;
	logic [23:0] c_icolor;

	mode_t       p_mode;
	logic [7:0]  p_held[2];
	int          p_held_n;
	int          p_openers;
	logic [15:0] p_x, p_y;
	logic [9:0]  p_size;
	logic [23:0] p_color;
	int          p_accum;
	int          p_field;

	logic [7:0]  la[3];           // held bytes plus the new one
	int          la_n;
	bit          la_fin;
	draw_t       step_draws[$];

	function automatic void restart_layout();
		p_mode    = M_TOP;
		p_held[0] = 8'h00;
		p_held[1] = 8'h00;
		p_held_n  = 0;
		p_openers = 0;
		p_x       = c_ox;
		p_y       = c_oy;
		p_size    = c_isize;
		p_color   = c_icolor;
		p_accum   = 0;
		p_field   = 0;
	endfunction

	// positions past the end of the text match nothing
	function automatic int peek_at(int k);
		return k < la_n ? int'(la[k]) : 256;
	endfunction

	// a lookahead position is decided once it is present or the text has ended
	function automatic bit have(int k);
		return k < la_n || la_fin;
	endfunction

	function automatic void drop(int k);
		if (k > la_n)
			k = la_n;
		for (int i = 0; i + k < la_n; i++)
			la[i] = la[i + k];
		la_n -= k;
	endfunction

	function automatic void open_color_tag();
		drop(2);
		p_accum = 0;
		p_field = 0;
		p_mode  = M_CSP;
	endfunction

	// one parser move; 0 when it needs a byte that has not arrived yet
	function automatic bit parse_once();
		int c;
		int sh;
		int digit;
		digit = CH_0 + c_section;
		if (la_n < 1)
			return 1'b0;
		case (p_mode)
			M_TOP: begin
				// section opener
				if (peek_at(0) == CH_LBRACK) begin
					if (!have(1))
						return 1'b0;
					if (peek_at(1) == CH_HASH) begin
						if (!have(2))
							return 1'b0;
						if (peek_at(2) == digit) begin
							drop(3);
							if (p_openers < 3)
								p_openers++;
						end
					end
				end
				p_mode = M_TERM;
			end
			M_TERM: begin
				// closer: the rest of the text is ignored
				if (peek_at(0) == CH_HASH) begin
					if (!have(1))
						return 1'b0;
					if (peek_at(1) == digit) begin
						if (!have(2))
							return 1'b0;
						if (peek_at(2) == CH_RBRACK) begin
							p_mode = M_DONE;
							return 1'b1;
						end
					end
				end
				p_mode = M_BODY;
			end
			M_BODY: begin
				// outside the section or past a second opener: skip the byte
				if (p_openers != 1) begin
					drop(1);
					p_mode = M_TOP;
					return 1'b1;
				end
				if (peek_at(0) == CH_LBRACK) begin
					if (!have(1))
						return 1'b0;
					if (peek_at(1) == CH_PCT) begin
						drop(2);
						p_accum = 0;
						p_mode  = M_SIZE;
						return 1'b1;
					end
					if (peek_at(1) == CH_AT) begin
						open_color_tag();
						return 1'b1;
					end
				end
				p_mode = M_DRAW;
			end
			M_SIZE: begin
				c = peek_at(0);
				drop(1);
				if (c == CH_RBRACK) begin
					p_size  = 10'(p_accum);
					p_accum = 0;
					p_mode  = M_COLCHK;
				end else if (c >= CH_0 && c <= CH_9) begin
					p_accum = p_accum * 10 + c - CH_0;
					if (p_accum > 1023)
						p_accum = 1023;
				end
			end
			M_COLCHK: begin
				// a color tag may follow a size tag directly
				if (peek_at(0) == CH_LBRACK) begin
					if (!have(1))
						return 1'b0;
					if (peek_at(1) == CH_AT) begin
						open_color_tag();
						return 1'b1;
					end
				end
				p_mode = M_DRAW;
			end
			M_CSP: begin
				if (peek_at(0) == CH_SPACE)
					drop(1);
				else
					p_mode = M_CDIG;
			end
			M_CDIG: begin
				c = peek_at(0);
				drop(1);
				if (c >= CH_0 && c <= CH_9) begin
					p_accum = (p_accum * 10 + c - CH_0) & 255;
				end else begin
					// any non-digit closes the value: red, green, blue in turn
					sh = 16 - 8 * (p_field & 3);
					if (sh < 0)
						sh = 0;
					p_color = (p_color & ~(24'hFF << sh)) | (24'(p_accum & 255) << sh);
					p_accum = 0;
					if (p_field >= 2) begin
						p_field = 0;
						p_mode  = M_DRAW;
					end else begin
						p_field++;
						p_mode = M_CSP;
					end
				end
			end
			M_DRAW: begin
				c = peek_at(0);
				drop(1);
				if (c == CH_LF) begin
					p_y = p_y + 16'(p_size);
					p_x = c_ox;
				end else begin
					p_x = p_x + 16'(p_size >> 1);
					if (step_draws.size() < MAX_RES)
						step_draws.push_back('{glyph: 8'(c), x: p_x, y: p_y, size: p_size,
							red: p_color[23:16], green: p_color[15:8],
							blue: p_color[7:0], eor: 1'b0});
				end
				p_mode = M_TOP;
			end
			default: begin
				// after the closer every byte is swallowed
				drop(1);
			end
		endcase
		return 1'b1;
	endfunction

	// predict the draws released by one accepted character request
	function automatic void layout_char(logic [7:0] ch, logic last);
		la_n = 0;
		for (int i = 0; i < p_held_n; i++) begin
			la[la_n] = p_held[i];
			la_n++;
		end
		la[la_n] = ch;
		la_n++;
		la_fin = last;
		step_draws.delete();
		while (parse_once()) begin
		end
		if (la_fin) begin
			restart_layout();
		end else begin
			if (la_n > 2)
				la_n = 2;
			p_held[0] = 8'h00;
			p_held[1] = 8'h00;
			for (int i = 0; i < la_n; i++)
				p_held[i] = la[i];
			p_held_n = la_n;
		end
		if (step_draws.size() != 0)
			step_draws[step_draws.size() - 1].eor = 1'b1;
		foreach (step_draws[i])
			draws_expected.push_back(step_draws[i]);
	endfunction

	function automatic void check_field(string what, int unsigned want, int unsigned got);
		if (want != got) begin
			$display("%0t: %s expected %0h got %0h", $time, what, want, got);
			mismatches++;
		end
	endfunction

	// --------------------------------------------------------------------
	// Character driver: offers queued bytes, idles at random, and feeds
	// each accepted request to the predictor at the edge that takes it.
	// --------------------------------------------------------------------
	always @(posedge clk) begin : drive_chars
		char_req_t req;
		if (arst_n) begin
			if (char_if.valid && char_if.ready)
				layout_char(char_if.char_code, char_if.last_char);
			if (!char_if.valid || char_if.ready) begin
				if (text_queue.size() != 0 && (steady || $urandom_range(99) >= 30)) begin
					req = text_queue.pop_front();
					char_if.valid     <= 1'b1;
					char_if.char_code <= req.ch;
					char_if.last_char <= req.last;
				end else begin
					char_if.valid <= 1'b0;
				end
			end
		end
	end

	// --------------------------------------------------------------------
	// Glyph monitor: random back-pressure, in-order compare of every draw
	// --------------------------------------------------------------------
	always @(posedge clk) begin : watch_glyphs
		draw_t want;
		if (arst_n) begin
			if (glyph_if.valid && glyph_if.ready) begin
				if (draws_expected.size() == 0) begin
					$display("%0t: unexpected draw, expected none got glyph %0h", $time,
						glyph_if.glyph);
					mismatches++;
				end else begin
					want = draws_expected.pop_front();
					check_field("glyph", want.glyph, glyph_if.glyph);
					check_field("pos_x", want.x, glyph_if.pos_x);
					check_field("pos_y", want.y, glyph_if.pos_y);
					check_field("glyph_size", want.size, glyph_if.glyph_size);
					check_field("red", want.red, glyph_if.red);
					check_field("green", want.green, glyph_if.green);
					check_field("blue", want.blue, glyph_if.blue);
					check_field("end_of_run", want.eor, glyph_if.end_of_run);
				end
			end
			glyph_if.ready <= steady || $urandom_range(99) >= 30;
		end
	end

	// APB write: setup cycle, then access cycle; the register loads at the
	// edge that sees psel and penable both high
	task automatic cfg_write(logic [2:0] idx, logic [31:0] val);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		case (idx)
			REG_SECTION:    c_section = val[3:0];
			REG_ORIGIN_X:   c_ox      = val[15:0];
			REG_ORIGIN_Y:   c_oy      = val[15:0];
			REG_INIT_SIZE:  c_isize   = val[9:0];
			REG_INIT_COLOR: c_icolor  = val[23:0];
			default: ;
		endcase
	endtask

	task automatic set_config(logic [3:0] sec, logic [15:0] ox, logic [15:0] oy,
			logic [9:0] isz, logic [23:0] icol);
		cfg_write(REG_SECTION, 32'(sec));
		cfg_write(REG_ORIGIN_X, 32'(ox));
		cfg_write(REG_ORIGIN_Y, 32'(oy));
		cfg_write(REG_INIT_SIZE, 32'(isz));
		cfg_write(REG_INIT_COLOR, 32'(icol));
	endtask

	// sampled at the falling edge so every request and draw of the rising
	// edge has been booked; the tail covers bytes still in the pipeline
	task automatic settle();
		do
			@(negedge clk);
		while (text_queue.size() != 0 || char_if.valid || draws_expected.size() != 0);
		repeat (12) @(negedge clk);
	endtask

	// Random sprite texts, mostly well formed: noise, a section opener
	// (sometimes for another section), then plain text, newlines, size and
	// color tags, stray openers and closers. Some texts are cut short so
	// that the final byte lands inside a tag.
	task automatic queue_texts(int target);
		logic [7:0] t[$];
		logic [7:0] sec;
		int added;
		int r;
		added = 0;
		while (added < target) begin
			t.delete();
			sec = CH_0 + c_section;
			repeat ($urandom_range(0, 2))
				t.push_back(8'($urandom_range(255)));
			if ($urandom_range(99) < 85) begin
				t.push_back(CH_LBRACK);
				t.push_back(CH_HASH);
				t.push_back($urandom_range(9) == 0 ? 8'(CH_0 + $urandom_range(9)) : sec);
			end
			repeat ($urandom_range(2, 9)) begin
				r = $urandom_range(99);
				if (r < 40) begin
					t.push_back($urandom_range(1) ? 8'("a" + $urandom_range(25))
						: 8'($urandom_range(255)));
				end else if (r < 50) begin
					t.push_back(CH_LF);
				end else if (r < 65) begin
					t.push_back(CH_LBRACK);
					t.push_back(CH_PCT);
					repeat ($urandom_range(0, 4))
						t.push_back(8'(CH_0 + $urandom_range(9)));
					if ($urandom_range(99) < 15)
						t.push_back(8'($urandom_range(255)));
					t.push_back(CH_RBRACK);
				end else if (r < 80) begin
					t.push_back(CH_LBRACK);
					t.push_back(CH_AT);
					repeat (3) begin
						repeat ($urandom_range(0, 2))
							t.push_back(CH_SPACE);
						repeat ($urandom_range(0, 3))
							t.push_back(8'(CH_0 + $urandom_range(9)));
						t.push_back($urandom_range(1) ? 8'(",") : 8'($urandom_range(255)));
					end
				end else if (r < 86) begin
					t.push_back(CH_HASH);
					t.push_back(sec);
					t.push_back(CH_RBRACK);
				end else if (r < 90) begin
					t.push_back(CH_LBRACK);
					t.push_back(CH_HASH);
					t.push_back(sec);
				end else begin
					t.push_back(CH_LBRACK);
					t.push_back(8'($urandom_range(255)));
				end
			end
			if (t.size() > 4 && $urandom_range(99) < 15)
				repeat ($urandom_range(1, 3))
					void'(t.pop_back());
			foreach (t[i])
				text_queue.push_back('{ch: t[i], last: i == t.size() - 1});
			added += t.size();
		end
	endtask

	initial begin : stimulus
		logic [7:0] opening[$];
		arst_n            = 1'b0;
		psel              = 1'b0;
		penable           = 1'b0;
		pwrite            = 1'b0;
		paddr             = '0;
		pwdata            = '0;
		char_if.valid     = 1'b0;
		char_if.char_code = 8'h00;
		char_if.last_char = 1'b0;
		glyph_if.ready    = 1'b0;
		c_section         = RST_SECTION;
		c_ox              = RST_ORIGIN_X;
		c_oy              = RST_ORIGIN_Y;
		c_isize           = RST_INIT_SIZE;
		c_icolor          = RST_INIT_COLOR;
		restart_layout();
		repeat (3) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		// Directed text on reset settings: top byte value, newline, an
		// oversized size tag, a color tag right after it with a skipped
		// space, the byte after a tag, the closer, then a zero byte that
		// is ignored past the closer.
		opening = '{CH_LBRACK, CH_HASH, "1", 8'hFF, CH_LF,
			CH_LBRACK, CH_PCT, "2", "0", "0", "0", CH_RBRACK,
			CH_LBRACK, CH_AT, CH_SPACE, "9", ",", "7", ",", "3", ";", "Z",
			CH_HASH, "1", CH_RBRACK, 8'h00};
		foreach (opening[i])
			text_queue.push_back('{ch: opening[i], last: i == opening.size() - 1});
		queue_texts(32);
		settle();

		// low section digit, coordinates at the wrap point, largest size
		set_config(4'd0, 16'hFFFF, 16'hFFFF, 10'd1023, 24'h000000);
		queue_texts(32);
		settle();

		// high section digit, origin at zero, zero size
		set_config(4'd9, 16'h0000, 16'h0000, 10'd0, 24'hFFFFFF);
		queue_texts(32);
		settle();

		// random settings, both sides streaming without gaps
		set_config(4'($urandom_range(9)), 16'($urandom_range(65535)),
			16'($urandom_range(65535)), 10'($urandom_range(1023)),
			24'($urandom_range(24'hFFFFFF)));
		steady = 1'b1;
		queue_texts(32);
		settle();

		if (mismatches == 0 && draws_expected.size() == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	// watchdog, far beyond the slowest legal run
	initial begin : watchdog
		#2000000;
		$display("Mismatches found");
		$finish;
	end

endmodule
